// ===== hw/rtl/lclc_pkg.sv =====
package lclc_pkg;

    localparam int LIST_CAPACITY_DEF = 1024;
    localparam int PAYLOAD_BITS_DEF  = 64;

    localparam int          LAYER_W       = 8;
    localparam int          MASKED_LAYERS = 16;
    localparam logic [15:0] FULL_MASK     = 16'hFFFF;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_TRIM   = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  layer;
        logic [63:0] payload;
        logic [15:0] clear_mask;
        logic [10:0] keep_count;
        logic [9:0]  entry_index;
    } t_cmd_in;

    typedef struct packed {
        logic [10:0] entry_count;
        logic        overflow;
        logic        read_valid;
        logic [7:0]  read_layer;
        logic [63:0] read_payload;
    } t_cmd_out;

endpackage

// ===== hw/rtl/lclc_ram.sv =====
module lclc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/layered_command_list_compactor.sv =====
// Append: the sequencer goes to S_FIN once the beat is taken. Read: S_RD, then S_FIN.
// Clear by mask: one pass over the list (S_CMP), then S_FIN; a full mask skips the pass.
// Trim: a counting pass (S_CNT), a compare (S_CHK) and a compacting pass (S_CMP);
// no compacting pass when nothing is dropped, no pass at all on an empty list or a keep count at or above capacity.
// One command at a time: input is ready again from the cycle the result turns valid;
// a stalled result holds the sequencer. Sync active-low reset empties the list.
module layered_command_list_compactor #(
    parameter int LIST_CAPACITY = lclc_pkg::LIST_CAPACITY_DEF,
    parameter int PAYLOAD_BITS  = lclc_pkg::PAYLOAD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lclc_pkg::t_cmd_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lclc_pkg::t_cmd_out o_out_data
);

    import lclc_pkg::*;

    localparam int AW = $clog2(LIST_CAPACITY);
    localparam int LW = $clog2(LIST_CAPACITY + 1);
    localparam int MW = (LW > 11) ? LW : 11;
    localparam int DW = LAYER_W + PAYLOAD_BITS;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;  // read data returning from RAM
    localparam logic [2:0] S_CNT  = 3'd2;  // trim: count entries of the layer
    localparam logic [2:0] S_CHK  = 3'd3;  // trim: compare count with keep
    localparam logic [2:0] S_CMP  = 3'd4;  // compacting pass (clear and trim)
    localparam logic [2:0] S_FIN  = 3'd5;  // hand result to output register

    logic [2:0]              r_state, n_state;
    logic [LW-1:0]           r_len, n_len;
    logic [LW-1:0]           r_src, n_src;
    logic [LW-1:0]           r_dst, n_dst;
    logic [LW-1:0]           r_cnt, n_cnt;
    logic [LW-1:0]           r_exc, n_exc;
    logic                    r_rv, n_rv;
    logic [1:0]              r_op, n_op;
    logic [LAYER_W-1:0]      r_lay, n_lay;
    logic [15:0]             r_mask, n_mask;
    logic [10:0]             r_keep, n_keep;
    logic                    r_ovf, n_ovf;
    logic                    r_rvld, n_rvld;
    logic [LAYER_W-1:0]      r_rlay, n_rlay;
    logic [PAYLOAD_BITS-1:0] r_rpay, n_rpay;
    logic                    r_o_valid, n_o_valid;
    t_cmd_out                r_o_data, n_o_data;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [DW-1:0]           ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [DW-1:0]           ram_rdata;
    logic [LAYER_W-1:0]      rd_layer;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    logic in_acc;
    logic issue;
    logic pass_done;
    logic drop;
    logic list_full;
    logic slot_free;

    lclc_ram #(
        .WIDTH (DW),
        .DEPTH (LIST_CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_layer = ram_rdata[DW-1 -: LAYER_W];
    assign rd_pay   = ram_rdata[PAYLOAD_BITS-1:0];

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    // Pass engine: one read issued per cycle, its data checked in the cycle after.
    assign issue     = (r_src < r_len);
    assign pass_done = !issue && !r_rv;
    assign list_full = (r_len == LW'(LIST_CAPACITY));
    assign slot_free = !r_o_valid || i_out_ready;

    always_comb begin
        if (r_op == CMD_CLEAR) begin
            drop = (rd_layer < LAYER_W'(MASKED_LAYERS)) && r_mask[rd_layer[3:0]];
        end else begin
            drop = (rd_layer == r_lay) && (r_exc != '0);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_src     = r_src;
        n_dst     = r_dst;
        n_cnt     = r_cnt;
        n_exc     = r_exc;
        n_rv      = r_rv;
        n_op      = r_op;
        n_lay     = r_lay;
        n_mask    = r_mask;
        n_keep    = r_keep;
        n_ovf     = r_ovf;
        n_rvld    = r_rvld;
        n_rlay    = r_rlay;
        n_rpay    = r_rpay;
        n_o_valid = r_o_valid;
        n_o_data  = r_o_data;

        ram_we    = 1'b0;
        ram_waddr = AW'(r_dst);
        ram_wdata = ram_rdata;
        ram_raddr = AW'(r_src);

        // Drain the output register independently of the sequencer.
        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = AW'(i_in_data.entry_index);
                if (in_acc) begin
                    n_op   = i_in_data.cmd;
                    n_lay  = i_in_data.layer;
                    n_mask = i_in_data.clear_mask;
                    n_keep = i_in_data.keep_count;
                    n_ovf  = 1'b0;
                    n_rvld = 1'b0;
                    n_rlay = '0;
                    n_rpay = '0;
                    n_src  = '0;
                    n_dst  = '0;
                    n_cnt  = '0;
                    n_rv   = 1'b0;
                    unique case (i_in_data.cmd)
                        CMD_APPEND: begin
                            // Write at the tail, or drop and flag when full.
                            if (list_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_len);
                                ram_wdata = {i_in_data.layer,
                                             i_in_data.payload[PAYLOAD_BITS-1:0]};
                                n_len     = r_len + 1'b1;
                            end
                            n_state = S_FIN;
                        end
                        CMD_CLEAR: begin
                            // Full mask empties everything, high layers too.
                            if (i_in_data.clear_mask == FULL_MASK) begin
                                n_len   = '0;
                                n_state = S_FIN;
                            end else begin
                                n_state = S_CMP;
                            end
                        end
                        CMD_TRIM: begin
                            if (r_len == '0 ||
                                32'(i_in_data.keep_count) >= 32'(LIST_CAPACITY)) begin
                                n_state = S_FIN;
                            end else begin
                                n_state = S_CNT;
                            end
                        end
                        CMD_READ: begin
                            n_rvld  = (32'(i_in_data.entry_index) < 32'(r_len));
                            n_state = S_RD;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_RD: begin
                // Hold zeros for an out-of-range index.
                if (r_rvld) begin
                    n_rlay = rd_layer;
                    n_rpay = rd_pay;
                end
                n_state = S_FIN;
            end
            S_CNT: begin
                n_src = issue ? r_src + 1'b1 : r_src;
                n_rv  = issue;
                if (r_rv && rd_layer == r_lay) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (pass_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (MW'(r_cnt) <= MW'(r_keep)) begin
                    n_state = S_FIN;
                end else begin
                    n_exc   = LW'(MW'(r_cnt) - MW'(r_keep));
                    n_src   = '0;
                    n_dst   = '0;
                    n_rv    = 1'b0;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_src = issue ? r_src + 1'b1 : r_src;
                n_rv  = issue;
                if (r_rv) begin
                    if (drop) begin
                        if (r_op == CMD_TRIM) begin
                            n_exc = r_exc - 1'b1;
                        end
                    end else begin
                        // Move the survivor down; dst never passes src.
                        ram_we = 1'b1;
                        n_dst  = r_dst + 1'b1;
                    end
                end
                if (pass_done) begin
                    n_len   = r_dst;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    n_o_valid              = 1'b1;
                    n_o_data.entry_count   = 11'(r_len);
                    n_o_data.overflow      = r_ovf;
                    n_o_data.read_valid    = r_rvld;
                    n_o_data.read_layer    = r_rlay;
                    n_o_data.read_payload  = 64'(r_rpay);
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_rv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_rv      <= n_rv;
            r_o_valid <= n_o_valid;
        end
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_cnt    <= n_cnt;
        r_exc    <= n_exc;
        r_op     <= n_op;
        r_lay    <= n_lay;
        r_mask   <= n_mask;
        r_keep   <= n_keep;
        r_ovf    <= n_ovf;
        r_rvld   <= n_rvld;
        r_rlay   <= n_rlay;
        r_rpay   <= n_rpay;
        r_o_data <= n_o_data;
    end

    // List length never grows past capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(LIST_CAPACITY))
        else $error("list length above capacity");

    // Compaction writes never overtake the read pointer.
    a_dst_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_dst <= r_src))
        else $error("compaction destination ahead of source");

    // An append into a non-full list grows it by exactly one.
    a_append_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.cmd == CMD_APPEND && !list_full)
            |=> (r_len == LW'($past(r_len) + 1'b1)))
        else $error("append did not grow the list");

    // RAM writes happen only on append acceptance or during compaction.
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (in_acc || r_state == S_CMP))
        else $error("unexpected entry write");

endmodule

// ===== bench/layered_command_list_compactor_test.sv =====
`timescale 1ns / 100ps

module layered_command_list_compactor_test;
    import lclc_pkg::*;

    localparam int LIST_CAP     = LIST_CAPACITY_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    // Longest command is a trim over a full list: two passes plus setup.
    localparam int SETTLE_WAIT  = 2 * LIST_CAP + 16;
    localparam int REPORT_LINES = 40;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_ready;
    t_cmd_in  i_in_data   = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_cmd_out o_out_data;

    layered_command_list_compactor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the command list, advanced once per accepted beat.
    logic [7:0]  list_layers   [0:LIST_CAP-1];
    logic [63:0] list_payloads [0:LIST_CAP-1];
    int          list_len = 0;

    t_cmd_out    pending_results[$];
    t_cmd_out    want;
    int          error_count      = 0;
    int          cycle_count      = 0;
    bit          jitter_on        = 1'b1;
    int          out_stall_cycles = 0;

    // Apply one command to the shadow list and return the result it must produce.
    function automatic t_cmd_out apply_command(input t_cmd_in c);
        t_cmd_out    r;
        int          dst;
        int          total;
        int          removed;
        logic [7:0]  lay;
        r       = '0;
        dst     = 0;
        total   = 0;
        removed = 0;
        case (c.cmd)
            CMD_APPEND: begin
                if (list_len < LIST_CAP) begin
                    list_layers[list_len]   = c.layer;
                    list_payloads[list_len] = c.payload;
                    list_len++;
                end else begin
                    // Full list: drop the command and flag it.
                    r.overflow = 1'b1;
                end
            end
            CMD_CLEAR: begin
                if (c.clear_mask == FULL_MASK) begin
                    list_len = 0;
                end else begin
                    // Keep layers 16 and up, and any layer whose mask bit is clear.
                    for (int i = 0; i < list_len; i++) begin
                        lay = list_layers[i];
                        if (lay >= MASKED_LAYERS || !c.clear_mask[lay[3:0]]) begin
                            list_layers[dst]   = list_layers[i];
                            list_payloads[dst] = list_payloads[i];
                            dst++;
                        end
                    end
                    list_len = dst;
                end
            end
            CMD_TRIM: begin
                if (list_len != 0 && c.keep_count < LIST_CAP) begin
                    for (int i = 0; i < list_len; i++)
                        if (list_layers[i] == c.layer) total++;
                    // Drop the oldest entries of the layer until keep_count remain.
                    if (total > c.keep_count) begin
                        for (int i = 0; i < list_len; i++) begin
                            if (list_layers[i] == c.layer && removed < total - c.keep_count) begin
                                removed++;
                            end else begin
                                list_layers[dst]   = list_layers[i];
                                list_payloads[dst] = list_payloads[i];
                                dst++;
                            end
                        end
                        list_len = dst;
                    end
                end
            end
            CMD_READ: begin
                if (c.entry_index < list_len) begin
                    r.read_valid   = 1'b1;
                    r.read_layer   = list_layers[c.entry_index];
                    r.read_payload = list_payloads[c.entry_index];
                end
            end
            default: ;
        endcase
        r.entry_count = 11'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < REPORT_LINES)
            $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, exp_val));
    endtask

    // Compare every accepted result beat with the oldest pending expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                want = pending_results.pop_front();
                check_field("entry_count",  o_out_data.entry_count,  want.entry_count);
                check_field("overflow",     o_out_data.overflow,     want.overflow);
                check_field("read_valid",   o_out_data.read_valid,   want.read_valid);
                check_field("read_layer",   o_out_data.read_layer,   want.read_layer);
                check_field("read_payload", o_out_data.read_payload, want.read_payload);
            end
        end
    end

    // Drop out_ready at random, or hold it low while a stall count runs down.
    initial begin : result_side
        forever begin
            @(negedge i_clk);
            if (out_stall_cycles > 0) begin
                i_out_ready <= 1'b0;
                out_stall_cycles--;
            end else begin
                i_out_ready <= !jitter_on || ($urandom_range(99) >= 27);
            end
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("layered_command_list_compactor verification failed");
            $finish;
        end
    end

    // Offer one beat after an optional random gap; hold it until taken.
    // Valid stays high afterwards, so back-to-back beats follow without a gap.
    task automatic send_beat(input t_cmd_in beat);
        while (jitter_on && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(apply_command(beat));
        @(negedge i_clk);
    endtask

    // Random filler in the fields that the operation ignores.
    function automatic t_cmd_in noise_beat(input logic [1:0] op);
        t_cmd_in b;
        b.cmd         = op;
        b.layer       = 8'($urandom);
        b.payload     = {$urandom, $urandom};
        b.clear_mask  = 16'($urandom);
        b.keep_count  = 11'($urandom);
        b.entry_index = 10'($urandom);
        return b;
    endfunction

    task automatic do_append(input logic [7:0] layer, input logic [63:0] payload);
        t_cmd_in b;
        b         = noise_beat(CMD_APPEND);
        b.layer   = layer;
        b.payload = payload;
        send_beat(b);
    endtask

    task automatic do_clear(input logic [15:0] mask);
        t_cmd_in b;
        b            = noise_beat(CMD_CLEAR);
        b.clear_mask = mask;
        send_beat(b);
    endtask

    task automatic do_trim(input logic [7:0] layer, input logic [10:0] keep);
        t_cmd_in b;
        b            = noise_beat(CMD_TRIM);
        b.layer      = layer;
        b.keep_count = keep;
        send_beat(b);
    endtask

    task automatic do_read(input logic [9:0] index);
        t_cmd_in b;
        b             = noise_beat(CMD_READ);
        b.entry_index = index;
        send_beat(b);
    endtask

    // Empty-list corners, extreme layers and payloads, every trim and clear rule.
    task automatic test_directed_ops();
        do_read(10'd0);
        do_trim(8'd0, 11'd0);
        do_clear(16'h0000);
        do_append(8'd0,   64'h0);
        do_append(8'd15,  {64{1'b1}});
        do_append(8'd16,  64'hAAAA_AAAA_AAAA_AAAA);
        do_append(8'd255, 64'h5555_5555_5555_5555);
        do_append(8'd7,   64'h1);
        do_append(8'd7,   64'h8000_0000_0000_0000);
        do_append(8'd7,   64'h0123_4567_89AB_CDEF);
        do_read(10'd3);
        do_read(10'd1023);
        do_trim(8'd7, 11'd1);
        do_trim(8'd7, 11'd5);
        do_trim(8'd255, 11'd1024);
        do_trim(8'd255, 11'd2047);
        do_trim(8'd255, 11'd0);
        do_read(10'd0);
        do_clear(16'h8001);
        do_read(10'd0);
        // Bits 1 to 14 set, bits 0 and 15 clear: layer 16 must survive.
        do_clear(16'h7FFE);
        do_read(10'd0);
        do_clear(FULL_MASK);
        do_read(10'd0);
    endtask

    // Run a long stretch without any idling on either side, then trim and read around it.
    task automatic test_no_idle_burst();
        jitter_on = 1'b0;
        do_clear(FULL_MASK);
        for (int i = 0; i < 48; i++)
            do_append(8'($urandom_range(0, 31)), {$urandom, $urandom});
        do_trim(8'($urandom_range(0, 31)), 11'd1024);
        do_append(8'd200, {$urandom, $urandom});
        do_append(8'd3, 64'hFFFF_0000_FFFF_0000);
        do_read(10'd1023);
        do_read(10'd0);
        do_read(10'd40);
        do_trim(list_layers[5], 11'd0);
        do_read(10'd1023);
        do_append(8'd99, {$urandom, $urandom});
        do_clear(16'($urandom));
        do_read(10'($urandom_range(0, 63)));
        do_clear(FULL_MASK);
        jitter_on = 1'b1;
    endtask

    // Hold the result side off while the sender keeps offering beats.
    task automatic test_result_stall();
        out_stall_cycles = 400;
        for (int i = 0; i < 16; i++) begin
            if (i % 3 == 2) do_read(10'($urandom_range(0, 15)));
            else            do_append(8'($urandom_range(0, 19)), {$urandom, $urandom});
        end
    endtask

    function automatic logic [7:0] pick_layer();
        if ($urandom_range(99) < 75) return 8'($urandom_range(0, 19));
        return 8'($urandom);
    endfunction

    // Mostly appends and reads, with clears and with trims aimed mostly at layers in the list.
    task automatic test_random_mix(input int n_beats);
        int          r;
        logic [15:0] mask;
        logic [7:0]  lay;
        logic [10:0] keep;
        for (int n = 0; n < n_beats; n++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                do_append(pick_layer(), {$urandom, $urandom});
            end else if (r < 70) begin
                if ($urandom_range(99) < 80)
                    do_read(10'($urandom_range(0, (list_len + 2 > 1023) ? 1023 : list_len + 2)));
                else
                    do_read(10'($urandom));
            end else if (r < 85) begin
                lay = (list_len > 0 && $urandom_range(99) < 70) ?
                      list_layers[$urandom_range(0, list_len - 1)] : pick_layer();
                r = $urandom_range(99);
                if (r < 80)      keep = 11'($urandom_range(0, 3));
                else if (r < 90) keep = 11'($urandom);
                else             keep = 11'(LIST_CAP);
                do_trim(lay, keep);
            end else begin
                r = $urandom_range(99);
                if (r < 40)      mask = 16'(1) << $urandom_range(0, 15);
                else if (r < 70) mask = 16'($urandom);
                else if (r < 80) mask = FULL_MASK;
                else if (r < 90) mask = 16'h0000;
                else             mask = 16'hFFFE;
                do_clear(mask);
            end
        end
    endtask

    initial begin : run
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        test_no_idle_burst();
        test_result_stall();
        test_random_mix(190);
        // Release the input, drain, and give the block time to misbehave.
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_WAIT) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0) begin
            $display("layered_command_list_compactor verification clean");
        end else begin
            $display("layered_command_list_compactor verification failed");
        end
        $finish;
    end

endmodule
